// ===== hw/rtl/gbl_pkg.sv =====
package gbl_pkg;

   localparam int FIRST_LOGO_WIDTH   = 256;
   localparam int FIRST_LOGO_HEIGHT  = 128;
   localparam int SECOND_LOGO_WIDTH  = 256;
   localparam int SECOND_LOGO_HEIGHT = 256;
   localparam int BOTTOM_MARGIN      = 200;

   localparam int LOGO_MEM_DEPTH = 65536;

   localparam int FL_DEPTH = (FIRST_LOGO_WIDTH * FIRST_LOGO_HEIGHT > LOGO_MEM_DEPTH) ?
                             LOGO_MEM_DEPTH : FIRST_LOGO_WIDTH * FIRST_LOGO_HEIGHT;
   localparam int SL_DEPTH = (SECOND_LOGO_WIDTH * SECOND_LOGO_HEIGHT > LOGO_MEM_DEPTH) ?
                             LOGO_MEM_DEPTH : SECOND_LOGO_WIDTH * SECOND_LOGO_HEIGHT;
   localparam int FL_AW = (FL_DEPTH > 1) ? $clog2(FL_DEPTH) : 1;
   localparam int SL_AW = (SL_DEPTH > 1) ? $clog2(SL_DEPTH) : 1;

   localparam int LOGO_IDX_W  = 10;
   localparam int ADDR_WIDE_W = 2 * LOGO_IDX_W + 1;
   localparam int POS_W       = 15;
   localparam int CFG_W       = 13;
   localparam int CNT_W       = 12;
   localparam int SIZE_MAX    = 4096;
   localparam int LOAD_AW     = 16;

   localparam logic [23:0] WHITE_RGB = 24'hFF_FFFF;
   localparam logic [15:0] WEIGHT_R  = 16'd13933;
   localparam logic [15:0] WEIGHT_G  = 16'd46871;
   localparam logic [15:0] WEIGHT_B  = 16'd4732;
   localparam logic [7:0]  FULL      = 8'd255;
   localparam logic [7:0]  NONE      = 8'd0;

   localparam logic [1:0] KIND_IMAGE       = 2'd0;
   localparam logic [1:0] KIND_FIRST_LOGO  = 2'd1;
   localparam logic [1:0] KIND_SECOND_LOGO = 2'd2;

   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_BOX_LEFT     = 3'd2;
   localparam logic [2:0] REG_BOX_RIGHT    = 3'd3;
   localparam logic [2:0] REG_BOX_TOP      = 3'd4;
   localparam logic [2:0] REG_BOX_BOTTOM   = 3'd5;

   typedef struct packed {
      logic [CFG_W-1:0]        width_eff;
      logic [CFG_W-1:0]        height_eff;
      logic [CNT_W-1:0]        box_left;
      logic [CNT_W-1:0]        box_right;
      logic [CNT_W-1:0]        box_top;
      logic [CNT_W-1:0]        box_bottom;
      logic signed [POS_W-1:0] fl_col;
      logic signed [POS_W-1:0] fl_row;
   } cfg_type;

   typedef struct packed {
      logic             outside;
      logic             box_edge;
      logic             fl_hit;
      logic             fl_black;
      logic [FL_AW-1:0] fl_addr;
      logic             sl_hit;
      logic [SL_AW-1:0] sl_addr;
      logic             frame_end;
   } loc_type;

   typedef struct packed {
      logic        outside;
      logic        box_edge;
      logic        fl_hit;
      logic        fl_black;
      logic        sl_hit;
      logic        frame_end;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] prod_r;
      logic [23:0] prod_g;
      logic [23:0] prod_b;
   } stage_type;

endpackage

// ===== hw/rtl/gbl_csr.sv =====
module gbl_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [12:0]        csr_wdata,
   output gbl_pkg::cfg_type   cfg
);
   import gbl_pkg::*;

   logic [CFG_W-1:0] image_width_ff, image_width_in;
   logic [CFG_W-1:0] image_height_ff, image_height_in;
   logic [CNT_W-1:0] box_left_ff, box_left_in;
   logic [CNT_W-1:0] box_right_ff, box_right_in;
   logic [CNT_W-1:0] box_top_ff, box_top_in;
   logic [CNT_W-1:0] box_bottom_ff, box_bottom_in;

   logic [CFG_W-1:0]        width_eff, height_eff;
   logic signed [POS_W-1:0] diff, adj, half;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      box_left_in     = box_left_ff;
      box_right_in    = box_right_ff;
      box_top_in      = box_top_ff;
      box_bottom_in   = box_bottom_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            REG_IMAGE_HEIGHT: image_height_in = csr_wdata;
            REG_BOX_LEFT:     box_left_in     = csr_wdata[CNT_W-1:0];
            REG_BOX_RIGHT:    box_right_in    = csr_wdata[CNT_W-1:0];
            REG_BOX_TOP:      box_top_in      = csr_wdata[CNT_W-1:0];
            REG_BOX_BOTTOM:   box_bottom_in   = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_W'(640);
         image_height_ff <= CFG_W'(480);
         box_left_ff     <= '0;
         box_right_ff    <= '0;
         box_top_ff      <= '0;
         box_bottom_ff   <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         box_left_ff     <= box_left_in;
         box_right_ff    <= box_right_in;
         box_top_ff      <= box_top_in;
         box_bottom_ff   <= box_bottom_in;
      end
   end

   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = CFG_W'(1);
      end else if (image_width_ff > CFG_W'(SIZE_MAX)) begin
         width_eff = CFG_W'(SIZE_MAX);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = CFG_W'(1);
      end else if (image_height_ff > CFG_W'(SIZE_MAX)) begin
         height_eff = CFG_W'(SIZE_MAX);
      end else begin
         height_eff = image_height_ff;
      end

      // (w - logo width) / 2, rounding toward zero
      diff = signed'(POS_W'(width_eff)) - signed'(POS_W'(FIRST_LOGO_WIDTH));
      adj  = diff + signed'({{(POS_W-1){1'b0}}, diff[POS_W-1]});
      half = adj >>> 1;

      cfg.width_eff  = width_eff;
      cfg.height_eff = height_eff;
      cfg.box_left   = box_left_ff;
      cfg.box_right  = box_right_ff;
      cfg.box_top    = box_top_ff;
      cfg.box_bottom = box_bottom_ff;
      cfg.fl_col     = half - signed'(POS_W'(1));
      cfg.fl_row     = signed'(POS_W'(height_eff))
                       - signed'(POS_W'(BOTTOM_MARGIN + FIRST_LOGO_HEIGHT + 1));
   end

endmodule

// ===== hw/rtl/gbl_locate.sv =====
module gbl_locate (
   input  logic             clock,
   input  logic             reset,
   input  logic             pixel_go,
   input  gbl_pkg::cfg_type cfg,
   output gbl_pkg::loc_type loc
);
   import gbl_pkg::*;

   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;

   logic signed [POS_W-1:0] lx, ly;
   logic [ADDR_WIDE_W-1:0]  fl_wide, sl_wide;
   logic [CNT_W-1:0]        col_m1, row_m1;
   logic                    col_inner, row_inner, last_col, last_row, fl_in;
   logic                    sl_in;

   always_comb begin
      lx = signed'(POS_W'(column_count_ff)) - cfg.fl_col;
      ly = signed'(POS_W'(row_count_ff)) - cfg.fl_row;
      fl_in = !lx[POS_W-1] && (lx < signed'(POS_W'(FIRST_LOGO_WIDTH)))
              && !ly[POS_W-1] && (ly < signed'(POS_W'(FIRST_LOGO_HEIGHT)));
      fl_wide = ADDR_WIDE_W'(ly[LOGO_IDX_W-1:0]) * ADDR_WIDE_W'(FIRST_LOGO_WIDTH)
                + ADDR_WIDE_W'(lx[LOGO_IDX_W-1:0]);

      col_m1 = column_count_ff - CNT_W'(1);
      row_m1 = row_count_ff - CNT_W'(1);
      sl_in  = (column_count_ff != '0) && (column_count_ff <= CNT_W'(SECOND_LOGO_WIDTH))
               && (row_count_ff != '0) && (row_count_ff <= CNT_W'(SECOND_LOGO_HEIGHT));
      sl_wide = ADDR_WIDE_W'(row_m1[LOGO_IDX_W-1:0]) * ADDR_WIDE_W'(SECOND_LOGO_WIDTH)
                + ADDR_WIDE_W'(col_m1[LOGO_IDX_W-1:0]);

      col_inner = (column_count_ff > cfg.box_left) && (column_count_ff < cfg.box_right);
      row_inner = (row_count_ff > cfg.box_top) && (row_count_ff < cfg.box_bottom);

      last_col = column_count_ff >= CNT_W'(cfg.width_eff - CFG_W'(1));
      last_row = row_count_ff >= CNT_W'(cfg.height_eff - CFG_W'(1));

      loc.outside  = (column_count_ff < cfg.box_left) || (column_count_ff > cfg.box_right)
                     || (row_count_ff < cfg.box_top) || (row_count_ff > cfg.box_bottom);
      loc.box_edge = (((column_count_ff == cfg.box_left) || (column_count_ff == cfg.box_right))
                      && row_inner)
                     || (((row_count_ff == cfg.box_top) || (row_count_ff == cfg.box_bottom))
                      && col_inner);
      loc.fl_hit    = fl_in;
      loc.fl_black  = fl_wide >= ADDR_WIDE_W'(FL_DEPTH);
      loc.fl_addr   = fl_wide[FL_AW-1:0];
      loc.sl_hit    = sl_in && (sl_wide < ADDR_WIDE_W'(SL_DEPTH));
      loc.sl_addr   = sl_wide[SL_AW-1:0];
      loc.frame_end = last_col && last_row;

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (pixel_go) begin
         if (last_col && last_row) begin
            column_count_in = '0;
            row_count_in    = '0;
         end else if (last_col) begin
            column_count_in = '0;
            row_count_in    = row_count_ff + CNT_W'(1);
         end else begin
            column_count_in = column_count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

// ===== hw/rtl/gbl_logo_mem.sv =====
module gbl_logo_mem (
   input  logic                       clock,
   input  logic                       advance,
   input  logic                       fl_load,
   input  logic                       sl_load,
   input  logic [15:0]                wr_addr,
   input  logic [23:0]                wr_rgb,
   input  logic [gbl_pkg::FL_AW-1:0]  fl_rd_addr,
   input  logic [gbl_pkg::SL_AW-1:0]  sl_rd_addr,
   output logic [23:0]                fl_data_ff,
   output logic                       sl_data_ff
);
   import gbl_pkg::*;

   logic [23:0] fl_mem [FL_DEPTH];
   logic        sl_mem [SL_DEPTH];

   logic fl_we, sl_we;

   assign fl_we = advance && fl_load && (int'(wr_addr) < FL_DEPTH);
   assign sl_we = advance && sl_load && (int'(wr_addr) < SL_DEPTH);

   always_ff @(posedge clock) begin
      if (fl_we) begin
         fl_mem[wr_addr[FL_AW-1:0]] <= wr_rgb;
      end
      if (advance) begin
         fl_data_ff <= fl_mem[fl_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sl_we) begin
         sl_mem[wr_addr[SL_AW-1:0]] <= (wr_rgb != WHITE_RGB);
      end
      if (advance) begin
         sl_data_ff <= sl_mem[sl_rd_addr];
      end
   end

endmodule

// ===== hw/rtl/gbl_shade.sv =====
module gbl_shade (
   input  gbl_pkg::stage_type stage,
   input  logic [23:0]        fl_data,
   input  logic               sl_bit,
   output logic [7:0]         pix_red,
   output logic [7:0]         pix_green,
   output logic [7:0]         pix_blue
);
   import gbl_pkg::*;

   logic [23:0] luma_sum;
   logic [23:0] logo_rgb;
   logic [7:0]  gray;

   always_comb begin
      luma_sum = stage.prod_r + stage.prod_g + stage.prod_b;
      gray     = luma_sum[23:16];
      logo_rgb = stage.fl_black ? 24'h00_0000 : fl_data;

      if (stage.outside) begin
         pix_red   = gray;
         pix_green = gray;
         pix_blue  = gray;
      end else if (stage.box_edge) begin
         pix_red   = NONE;
         pix_green = FULL;
         pix_blue  = NONE;
      end else begin
         pix_red   = stage.red;
         pix_green = stage.green;
         pix_blue  = stage.blue;
      end

      if (stage.fl_hit && (logo_rgb != WHITE_RGB)) begin
         pix_red   = logo_rgb[23:16];
         pix_green = logo_rgb[15:8];
         pix_blue  = logo_rgb[7:0];
      end

      if (stage.sl_hit && sl_bit) begin
         pix_red  = FULL;
         pix_blue = FULL;
      end
   end

endmodule

// ===== hw/rtl/grayscale_box_logo_overlay.sv =====
// Registers: a result reaches rsp through the input register (loaded at the req transfer),
// then the logo memory read register, then the output register.
// Throughput: one item per cycle; the whole pipeline holds while rsp is stalled.
// Logo loads and unused kinds give no result.
// Reset: synchronous, active high; clears valids and counters, and sets config registers to defaults.
// Logo memories are not cleared and must be loaded before use.
module grayscale_box_logo_overlay (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [39:0] req_tdata,   // red, green, blue, logo_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_red, out_green, out_blue
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import gbl_pkg::*;

   logic advance;

   logic        s0_valid_ff;
   logic [1:0]  s0_kind_ff;
   logic [7:0]  s0_red_ff, s0_green_ff, s0_blue_ff;
   logic [15:0] s0_addr_ff;

   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;

   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic        rsp_last_ff;

   cfg_type     cfg;
   loc_type     loc;
   logic        pixel_go;
   logic [23:0] fl_data;
   logic        sl_bit;
   logic [7:0]  pix_red, pix_green, pix_blue;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign pixel_go   = advance && s0_valid_ff && (s0_kind_ff == KIND_IMAGE);

   gbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbl_locate u_locate (
      .clock    (clock),
      .reset    (reset),
      .pixel_go (pixel_go),
      .cfg      (cfg),
      .loc      (loc)
   );

   gbl_logo_mem u_logo_mem (
      .clock      (clock),
      .advance    (advance),
      .fl_load    (s0_valid_ff && (s0_kind_ff == KIND_FIRST_LOGO)),
      .sl_load    (s0_valid_ff && (s0_kind_ff == KIND_SECOND_LOGO)),
      .wr_addr    (s0_addr_ff),
      .wr_rgb     ({s0_red_ff, s0_green_ff, s0_blue_ff}),
      .fl_rd_addr (loc.fl_addr),
      .sl_rd_addr (loc.sl_addr),
      .fl_data_ff (fl_data),
      .sl_data_ff (sl_bit)
   );

   always_comb begin
      s1_in.outside   = loc.outside;
      s1_in.box_edge  = loc.box_edge;
      s1_in.fl_hit    = loc.fl_hit;
      s1_in.fl_black  = loc.fl_black;
      s1_in.sl_hit    = loc.sl_hit;
      s1_in.frame_end = loc.frame_end;
      s1_in.red       = s0_red_ff;
      s1_in.green     = s0_green_ff;
      s1_in.blue      = s0_blue_ff;
      s1_in.prod_r    = 24'(s0_red_ff) * 24'(WEIGHT_R);
      s1_in.prod_g    = 24'(s0_green_ff) * 24'(WEIGHT_G);
      s1_in.prod_b    = 24'(s0_blue_ff) * 24'(WEIGHT_B);
   end

   gbl_shade u_shade (
      .stage     (s1_ff),
      .fl_data   (fl_data),
      .sl_bit    (sl_bit),
      .pix_red   (pix_red),
      .pix_green (pix_green),
      .pix_blue  (pix_blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_tvalid;
         s1_valid_ff  <= s0_valid_ff && (s0_kind_ff == KIND_IMAGE);
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_kind_ff  <= req_tuser;
         s0_red_ff   <= req_tdata[7:0];
         s0_green_ff <= req_tdata[15:8];
         s0_blue_ff  <= req_tdata[23:16];
         s0_addr_ff  <= req_tdata[39:24];
         s1_ff       <= s1_in;
         rsp_data_ff <= {pix_blue, pix_green, pix_red};
         rsp_last_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/gbl_checker.sv =====
module gbl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);
   import gbl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req ready while rsp stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_pixel_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_IMAGE)) ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("image pixel result missing");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != KIND_IMAGE)) ##1 rsp_tready ##1 rsp_tready
      |=> !rsp_tvalid)
      else $error("load produced a result");

endmodule

bind grayscale_box_logo_overlay gbl_checker u_gbl_checker (.*);
